// ===== rtl/sem_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sem_pkg
// Shared types and constants for the Sobel edge magnitude block.
// ============================================================================
package sem_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;

   localparam int PIXEL_W     = 8;
   localparam int GRAD_W      = 11;
   localparam int ABS_W       = 10;
   localparam int SQ_W        = 2 * ABS_W;
   localparam int ROOT_W      = 16;
   localparam int ROOT_STEPS  = ROOT_W / 2;
   localparam int STEP_W      = $clog2(ROOT_STEPS);
   localparam int MAG_W       = 8;

   localparam int IMG_W_W     = 11;
   localparam int IMG_H_W     = 12;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 1;

   localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 12'd480;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic                     last;
   } grad_type;

   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] level;
   } queue_status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_ROOT = 4'b0100,
      ST_DONE = 4'b1000
   } back_state_type;

endpackage

// ===== rtl/sem_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sem_queue
// Small FIFO of gradient pairs between the window front end and the root unit.
// ============================================================================
module sem_queue
   import sem_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  grad_type         push_data,
   input  logic             pop,
   output grad_type         head,
   output queue_status_type status
);

   grad_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign status.empty = (level_ff == '0);
   assign status.level = level_ff;

endmodule

// ===== rtl/sem_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sem_front
// Configuration registers, raster counters, line stores and 3x3 window;
// forms the Sobel gradients of each interior pixel and queues them.
// ============================================================================
module sem_front
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_pixel,
   input  queue_status_type       q_status,
   output logic                   push,
   output grad_type               push_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

   logic [IMG_W_W-1:0] width_ff;
   logic [IMG_H_W-1:0] height_ff;

   logic [PIXEL_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIXEL_W-1:0] middle_mem [MAX_WIDTH];

   logic [CW-1:0]      col_ff, col_in;
   logic [IMG_H_W-1:0] row_ff, row_in;

   logic               p1_valid_ff;
   logic               p1_emit_ff;
   logic               p1_last_ff;
   logic [CW-1:0]      p1_col_ff;
   logic [PIXEL_W-1:0] p1_pixel_ff;
   logic [PIXEL_W-1:0] top_rd_ff;
   logic [PIXEL_W-1:0] mid_rd_ff;

   logic [PIXEL_W-1:0] win_ff [6];

   logic               accept;
   logic [WW-1:0]      eff_w;
   logic [IMG_H_W-1:0] eff_h;
   logic [CW-1:0]      col_cur;
   logic [IMG_H_W-1:0] row_cur;
   logic               emit;
   logic               last;
   logic [QCNT_W:0]    occupancy;
   logic [ABS_W-1:0]   sum_right, sum_left, sum_top, sum_bot;

   // effective frame size
   always_comb begin
      eff_w = WW'(width_ff);
      if (eff_w < WW'(3)) begin
         eff_w = WW'(3);
      end else if (eff_w > WW'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end
      eff_h = (height_ff < IMG_H_W'(3)) ? IMG_H_W'(3) : height_ff;
   end

   always_comb begin
      col_cur = (WW'(col_ff) >= eff_w) ? '0 : col_ff;
      row_cur = (row_ff >= eff_h) ? '0 : row_ff;
      emit    = (row_cur >= IMG_H_W'(2)) && (col_cur >= CW'(2));
      last    = (row_cur == eff_h - 1'b1) && (WW'(col_cur) == eff_w - 1'b1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (WW'(col_cur) + 1'b1 >= eff_w) begin
            col_in = '0;
            row_in = ({1'b0, row_cur} + 1'b1 >= {1'b0, eff_h}) ? '0 : row_cur + 1'b1;
         end else begin
            col_in = col_cur + 1'b1;
            row_in = row_cur;
         end
      end
   end

   assign occupancy = {1'b0, q_status.level} + (QCNT_W + 1)'(p1_valid_ff & p1_emit_ff);
   assign req_stall = (occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[IMG_W_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[IMG_H_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         p1_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         p1_valid_ff <= accept;
         if (p1_valid_ff) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top_rd_ff;
            win_ff[4] <= mid_rd_ff;
            win_ff[5] <= p1_pixel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_emit_ff  <= emit;
         p1_last_ff  <= last;
         p1_col_ff   <= col_cur;
         p1_pixel_ff <= req_pixel;
      end
   end

   // line stores: read on transfer, write back in the following cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         top_rd_ff <= upper_mem[col_cur];
         mid_rd_ff <= middle_mem[col_cur];
      end
      if (p1_valid_ff) begin
         upper_mem[p1_col_ff]  <= mid_rd_ff;
         middle_mem[p1_col_ff] <= p1_pixel_ff;
      end
   end

   // gradients: right minus left column, top minus bottom row
   always_comb begin
      sum_right = {2'b00, top_rd_ff} + {1'b0, mid_rd_ff, 1'b0} + {2'b00, p1_pixel_ff};
      sum_left  = {2'b00, win_ff[0]} + {1'b0, win_ff[1], 1'b0} + {2'b00, win_ff[2]};
      sum_top   = {2'b00, win_ff[0]} + {1'b0, win_ff[3], 1'b0} + {2'b00, top_rd_ff};
      sum_bot   = {2'b00, win_ff[2]} + {1'b0, win_ff[5], 1'b0} + {2'b00, p1_pixel_ff};
      push_data.gx   = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
      push_data.gy   = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bot});
      push_data.last = p1_last_ff;
   end

   assign push = p1_valid_ff && p1_emit_ff;

endmodule

// ===== rtl/sem_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sem_back
// Squares and sums queued gradients, takes the saturated integer square
// root two bits per cycle, and holds the result in the output register.
// ============================================================================
module sem_back
   import sem_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  queue_status_type   q_status,
   input  grad_type           head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [MAG_W-1:0]   rsp_magnitude,
   output logic               rsp_last_of_frame
);

   back_state_type      state_ff, state_in;
   logic [SQ_W-1:0]     sq_x_ff, sq_x_in;
   logic [SQ_W-1:0]     sq_y_ff, sq_y_in;
   logic                last_ff, last_in;
   logic [ROOT_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   res_ff, res_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                out_valid_ff, out_valid_in;
   logic [MAG_W-1:0]    out_mag_ff, out_mag_in;
   logic                out_last_ff, out_last_in;

   logic [ABS_W-1:0]    abs_x, abs_y;
   logic [SQ_W:0]       sum;
   logic [ROOT_W-1:0]   bitv;
   logic [ROOT_W:0]     trial;
   logic                out_free;

   always_comb begin
      abs_x = head.gx[GRAD_W-1] ? ABS_W'(-head.gx) : ABS_W'(head.gx);
      abs_y = head.gy[GRAD_W-1] ? ABS_W'(-head.gy) : ABS_W'(head.gy);
      sum   = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
      bitv  = ROOT_W'(1) << {step_ff, 1'b0};
      trial = {1'b0, res_ff} + {1'b0, bitv};
      out_free = !out_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      sq_x_in      = sq_x_ff;
      sq_y_in      = sq_y_ff;
      last_in      = last_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_mag_in   = out_mag_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               sq_x_in  = abs_x * abs_x;
               sq_y_in  = abs_y * abs_y;
               last_in  = head.last;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            rem_in  = sum[ROOT_W-1:0];
            step_in = STEP_W'(ROOT_STEPS - 1);
            if (|sum[SQ_W:ROOT_W]) begin
               res_in   = ROOT_W'({MAG_W{1'b1}});
               state_in = ST_DONE;
            end else begin
               res_in   = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if ({1'b0, rem_ff} >= trial) begin
               rem_in = rem_ff - trial[ROOT_W-1:0];
               res_in = (res_ff >> 1) + bitv;
            end else begin
               res_in = res_ff >> 1;
            end
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_mag_in   = res_ff[MAG_W-1:0];
               out_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_x_ff     <= sq_x_in;
      sq_y_ff     <= sq_y_in;
      last_ff     <= last_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      step_ff     <= step_in;
      out_mag_ff  <= out_mag_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_magnitude     = out_mag_ff;
   assign rsp_last_of_frame = out_last_ff;

endmodule

// ===== rtl/sobel_edge_magnitude.sv =====
`timescale 1ns / 1ps
// Throughput: pixels pass at one per cycle while the 4-entry gradient queue
// has room; all of them stall while queued plus pending gradients fill it.
// The square-root unit works on one result at a time (8 two-bit root steps)
// and pops the next gradient pair only after the last result is registered.
// Reset: synchronous; clears counters, window, queue and output; size
// registers return to 640 x 480. Line stores are not cleared.
// ============================================================================
// sobel_edge_magnitude
// 3x3 Sobel gradient magnitude over a raster pixel stream.
// ============================================================================
module sobel_edge_magnitude
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [MAG_W-1:0]       rsp_magnitude,
   output logic                   rsp_last_of_frame
);

   queue_status_type q_status;
   grad_type         push_data;
   grad_type         head;
   logic             push;
   logic             pop;

   sem_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pixel (req_pixel),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   sem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   sem_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

// ===== bench/tb_sobel_edge_magnitude.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_sobel_edge_magnitude
// Self-checking bench for the Sobel gradient magnitude block. Pixel frames of
// many sizes are streamed in raster order. This includes clamped sizes and size
// changes in the middle of a frame. A bench-side line-buffer model predicts each
// magnitude and its end-of-frame flag. Both handshake sides idle at random.
// ============================================================================
module tb_sobel_edge_magnitude;
   import sem_pkg::*;

   localparam int SETTLE_CYCLES = 32;
   localparam int FILL_WIDTH    = 40;
   localparam int OVERSIZE_RUN  = 50;
   localparam int RANDOM_PIXELS = 300;

   typedef struct {
      bit [MAG_W-1:0] magnitude;
      bit             last_of_frame;
   } edge_result_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_pixel   = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b1;
   logic [MAG_W-1:0]       rsp_magnitude;
   logic                   rsp_last_of_frame;

   // bench-side image model
   bit [IMG_W_W-1:0]  cfg_width  = WIDTH_RESET;
   bit [IMG_H_W-1:0]  cfg_height = HEIGHT_RESET;
   bit [PIXEL_W-1:0]  upper_line [MAX_WIDTH_DEFAULT];
   bit [PIXEL_W-1:0]  middle_line[MAX_WIDTH_DEFAULT];
   bit [PIXEL_W-1:0]  window_px[6];
   int unsigned       col_pos = 0;
   int unsigned       row_pos = 0;
   edge_result_type   expected_edges[$];

   bit no_idle        = 1'b0;
   int error_count    = 0;
   int pixels_sent    = 0;
   int results_seen   = 0;
   int size_settings  = 0;
   int stall_left     = 0;

   sobel_edge_magnitude u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic int unsigned active_width();
      if (cfg_width < 3) return 3;
      if (cfg_width > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
      return 32'(cfg_width);
   endfunction

   function automatic int unsigned active_height();
      return (cfg_height < 3) ? 3 : 32'(cfg_height);
   endfunction

   function automatic bit at_frame_start();
      return (col_pos == 0 || col_pos >= active_width()) &&
             (row_pos == 0 || row_pos >= active_height());
   endfunction

   function automatic bit [MAG_W-1:0] root_sat(int unsigned v);
      bit [MAG_W-1:0] root;
      root = '0;
      if (v >= 65536) return 8'd255;
      for (int k = MAG_W - 1; k >= 0; k--) begin
         if ((int'(root) | (1 << k)) * (int'(root) | (1 << k)) <= v) root[k] = 1'b1;
      end
      return root;
   endfunction

   function automatic void predict_edge(bit [PIXEL_W-1:0] pix);
      int unsigned     w, h, c, r;
      int              top, mid, bot, gx, gy;
      edge_result_type res;
      w = active_width();
      h = active_height();
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      top = int'(upper_line[c]);
      mid = int'(middle_line[c]);
      bot = int'(pix);
      upper_line[c]  = mid[7:0];
      middle_line[c] = pix;
      if (r >= 2 && c >= 2) begin
         gx = (top + 2 * mid + bot) -
              (int'(window_px[0]) + 2 * int'(window_px[1]) + int'(window_px[2]));
         gy = (int'(window_px[0]) + 2 * int'(window_px[3]) + top) -
              (int'(window_px[2]) + 2 * int'(window_px[5]) + bot);
         res.magnitude     = root_sat(gx * gx + gy * gy);
         res.last_of_frame = (r == h - 1) && (c == w - 1);
         expected_edges.push_back(res);
      end
      window_px[0] = window_px[3];
      window_px[1] = window_px[4];
      window_px[2] = window_px[5];
      window_px[3] = top[7:0];
      window_px[4] = mid[7:0];
      window_px[5] = pix;
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic bit [PIXEL_W-1:0] any_pixel();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   // one pixel transfer; hold_off drains all pending results first
   task automatic send_pixel(bit [PIXEL_W-1:0] pix, bit hold_off = 1'b0);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0 || hold_off) begin
         req_valid <= 1'b0;
         if (hold_off) begin
            do @(posedge clock); while (expected_edges.size() != 0);
         end
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_edge(pix);
      pixels_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic wait_csr_transfer();
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_size(bit [CSR_DATA_W-1:0] w_data, bit [CSR_DATA_W-1:0] h_data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w_data;
      wait_csr_transfer();
      cfg_width = w_data[IMG_W_W-1:0];
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h_data;
      wait_csr_transfer();
      cfg_height = h_data[IMG_H_W-1:0];
      csr_valid <= 1'b0;
      size_settings++;
   endtask

   task automatic finish_frame();
      do send_pixel(any_pixel()); while (!at_frame_start());
   endtask

   // widest line of the random frames, fewest rows; fills those line-buffer entries
   task automatic test_fill_frame();
      write_size(CSR_DATA_W'(FILL_WIDTH), 12'd3);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 3 * FILL_WIDTH; i++) begin
         send_pixel(any_pixel());
      end
      no_idle = 1'b0;
   endtask

   task automatic test_directed_windows();
      bit [PIXEL_W-1:0] vert_edge[9] = '{0, 0, 255, 0, 0, 255, 0, 0, 255};
      bit [PIXEL_W-1:0] horz_edge[9] = '{255, 255, 255, 128, 128, 128, 0, 0, 0};
      bit [PIXEL_W-1:0] soft_ramp[9] = '{10, 12, 20, 11, 13, 25, 9, 15, 30};
      write_size(12'd3, 12'd3);
      foreach (vert_edge[i]) send_pixel(vert_edge[i]);
      // sizes below the minimum clamp to 3 x 3
      write_size(12'd0, 12'd1);
      foreach (horz_edge[i]) send_pixel(horz_edge[i]);
      write_size(12'd2, 12'd2);
      foreach (soft_ramp[i]) send_pixel(soft_ramp[i]);
   endtask

   // oversize width clamps; size writes mid-frame wrap the counters
   task automatic test_clamp_and_wrap();
      write_size(12'hFFF, 12'd4095);
      repeat (OVERSIZE_RUN) send_pixel(any_pixel());
      write_size(12'd5, 12'd4095);
      repeat (17) send_pixel(any_pixel());
      write_size(12'd5, 12'd3);
      finish_frame();
   endtask

   task automatic test_random_frames();
      int               stop_at;
      int               partial;
      bit [CSR_DATA_W-1:0] w_data, h_data;
      stop_at = pixels_sent + RANDOM_PIXELS;
      while (pixels_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0:       w_data = CSR_DATA_W'($urandom_range(0, 2));
            1:       w_data = CSR_DATA_W'($urandom_range(13, FILL_WIDTH));
            default: w_data = CSR_DATA_W'($urandom_range(3, 12));
         endcase
         w_data[IMG_W_W] = 1'($urandom_range(0, 1));
         h_data = CSR_DATA_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                          : $urandom_range(3, 8));
         write_size(w_data, h_data);
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) begin
            // broken frame: cut short, next size lands mid-frame
            partial = $urandom_range(1, active_width() * active_height() - 1);
            repeat (partial) send_pixel(any_pixel(), $urandom_range(0, 39) == 0);
         end else begin
            do send_pixel(any_pixel(), $urandom_range(0, 39) == 0);
            while (!at_frame_start());
         end
      end
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin : check_results
      edge_result_type want;
      int              n;
      if (reset) begin
         rsp_stall  <= 1'b1;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_edges.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, magnitude %0d last_of_frame %0b",
                     $time, rsp_magnitude, rsp_last_of_frame);
         end else begin
            want = expected_edges.pop_front();
            if (rsp_magnitude !== want.magnitude) begin
               error_count++;
               $display("%0t: magnitude expected %0d actual %0d",
                        $time, want.magnitude, rsp_magnitude);
            end
            if (rsp_last_of_frame !== want.last_of_frame) begin
               error_count++;
               $display("%0t: last_of_frame expected %0b actual %0b",
                        $time, want.last_of_frame, rsp_last_of_frame);
            end
         end
         n = no_idle ? 0 : $urandom_range(0, 13);
         stall_left <= n;
         rsp_stall  <= (n != 0);
      end else if (rsp_stall) begin
         if (stall_left <= 1) begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
         end else begin
            stall_left <= stall_left - 1;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_frame();
      test_directed_windows();
      test_clamp_and_wrap();
      test_random_frames();
      wait_idle();
      if (expected_edges.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected results never arrived", $time, expected_edges.size());
      end
      $display("Streamed %0d pixels over %0d frame size settings, checked %0d magnitudes",
               pixels_sent, size_settings, results_seen);
      $display("Frames spanned clamped, oversize and mid-frame sizes with random idling");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
